[hw/rtl/swms_pkg.sv]
// Shared types and constants for the sliding window median sum block.
// No dependencies.
package swms_pkg;
  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int SUM_BITS    = 48;
  localparam int PTR_BITS    = $clog2(MAX_WINDOW);
  localparam int CNT_BITS    = $clog2(MAX_WINDOW + 1);
  localparam int KCFG_BITS   = 7;
  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  // controller -> datapath commands
  typedef struct packed {
    logic take;       // latch input word, write ring
    logic clear;      // start request: clear sequence state
    logic cand_ld;    // load candidate i from ring
    logic cand_nx;    // advance candidate index after a failed pass
    logic cmp_clr;    // clear less/leq counters
    logic cmp_rd;     // issue read for compare element j
    logic cmp_acc;    // accumulate compare of returned element
    logic finish;     // update sum, load output register
  } swms_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic full;       // window filled after this sample
    logic last_i;     // candidate index at k-1
    logic last_j;     // all k compare reads issued
    logic hit;        // candidate is the wanted rank
  } swms_sts_t;
endpackage

[hw/rtl/sliding_window_median_sum.sv]
// Sliding window lower-median filter with saturating running sum of medians.
// Depends on swms_pkg, swms_ctrl, swms_datapath, swms_ram.
//
// When the window is not yet full, a word is only written to the ring and
// no result is produced. Otherwise the median is found by rank counting over
// the ring RAM (one read port): each candidate tested costs one pass of
// compare reads over the k newest words, testing 1..k candidates in turn
// until one has the wanted rank. The next word is accepted in the cycle
// after the previous result has been taken.
module sliding_window_median_sum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [swms_pkg::KCFG_BITS-1:0] cfg_wdata,   // window_size
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,     // [15:0] sample
  input  logic                          in_tuser,     // [0] start_req
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [63:0]                   out_tdata     // [15:0] median, [63:16] median_sum
);
  import swms_pkg::*;

  swms_cmd_t            cmd;
  swms_sts_t            sts;
  logic [KCFG_BITS-1:0] wsize_r;
  logic [15:0]          med;
  logic [SUM_BITS-1:0]  sum;

  // window size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r <= KCFG_BITS'(3);
    end else if (cfg_we) begin
      wsize_r <= cfg_wdata;
    end
  end

  swms_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_start(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cmd(cmd), .sts(sts)
  );

  swms_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .window_size(wsize_r), .in_sample(in_tdata),
    .out_median(med), .out_sum(sum)
  );

  assign out_tdata = {sum, med};
endmodule

[hw/rtl/swms_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module swms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/swms_datapath.sv]
// Datapath: sample ring, rank selection counters, running sum, output word.
// Depends on swms_pkg and swms_ram.
module swms_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  swms_pkg::swms_cmd_t            cmd,
  output swms_pkg::swms_sts_t            sts,
  input  logic [swms_pkg::KCFG_BITS-1:0] window_size,
  input  logic [15:0]                    in_sample,
  output logic [15:0]                    out_median,
  output logic [swms_pkg::SUM_BITS-1:0]  out_sum
);
  import swms_pkg::*;

  logic [PTR_BITS-1:0]    wpos_r, wpos_nxt;
  logic [CNT_BITS-1:0]    fill_r, fill_nxt;
  logic [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic [PTR_BITS-1:0]    i_r;
  logic [CNT_BITS-1:0]    j_r;
  logic [CNT_BITS-1:0]    less_r, leq_r;
  logic [SAMPLE_BITS-1:0] cand_r, rdata, med_r;
  logic [PTR_BITS-1:0]    raddr;
  logic [CNT_BITS-1:0]    k, rank;
  logic [PTR_BITS-1:0]    km1;
  logic [SUM_BITS:0]      sum_add;

  // effective window size and wanted rank
  always_comb begin
    if (window_size == '0) begin
      k = CNT_BITS'(1);
    end else if (window_size > KCFG_BITS'(MAX_WINDOW)) begin
      k = CNT_BITS'(MAX_WINDOW);
    end else begin
      k = CNT_BITS'(window_size);
    end
    rank = CNT_BITS'((k + CNT_BITS'(1)) >> 1);
    km1  = PTR_BITS'(k - CNT_BITS'(1));
  end

  // ring write pointer and fill count
  always_comb begin
    wpos_nxt = wpos_r;
    fill_nxt = fill_r;
    if (cmd.take) begin
      wpos_nxt = (cmd.clear ? '0 : wpos_r) + PTR_BITS'(1);
      fill_nxt = cmd.clear ? CNT_BITS'(1)
               : (fill_r < CNT_BITS'(MAX_WINDOW)) ? fill_r + CNT_BITS'(1) : fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else begin
      wpos_r <= wpos_nxt;
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

  // read address: element n back from newest is wpos-1-n
  always_comb begin
    if (cmd.cand_ld) begin
      raddr = wpos_r - PTR_BITS'(1) - i_r;
    end else begin
      raddr = wpos_r - PTR_BITS'(1) - PTR_BITS'(j_r);
    end
  end

  swms_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WINDOW)) u_ring (
    .clk   (clk),
    .we    (cmd.take),
    .waddr (cmd.clear ? '0 : wpos_r),
    .wdata (in_sample),
    .raddr (raddr),
    .rdata (rdata)
  );

  // selection indexes and counters
  always_ff @(posedge clk) begin
    // candidate index: restart on a new word, advance after a failed pass
    if (cmd.take) begin
      i_r <= '0;
    end else if (cmd.cand_nx) begin
      i_r <= i_r + PTR_BITS'(1);
    end
    if (cmd.cmp_clr) begin
      cand_r <= rdata;
      j_r    <= '0;
      less_r <= '0;
      leq_r  <= '0;
    end else begin
      if (cmd.cmp_rd) begin
        j_r <= j_r + CNT_BITS'(1);
      end
      if (cmd.cmp_acc) begin
        less_r <= less_r + CNT_BITS'(rdata <  cand_r);
        leq_r  <= leq_r  + CNT_BITS'(rdata <= cand_r);
      end
    end
  end

  assign sts.full   = (fill_nxt >= k);
  assign sts.last_i = (i_r == km1);
  assign sts.last_j = (j_r == k);
  assign sts.hit    = (less_r < rank) && (rank <= leq_r);

  // saturating sum and output register
  assign sum_add = {1'b0, sum_r} + (SUM_BITS+1)'(cand_r);
  always_comb begin
    sum_nxt = sum_r;
    if (cmd.take && cmd.clear) begin
      sum_nxt = '0;
    end else if (cmd.finish) begin
      sum_nxt = sum_add[SUM_BITS] ? SUM_MAX : sum_add[SUM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      med_r <= cand_r;
    end
  end

  assign out_median = med_r;
  assign out_sum    = sum_r;
endmodule

[hw/rtl/swms_ctrl.sv]
// Controller FSM sequencing intake, rank search and result handoff.
// Depends on swms_pkg.
module swms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_start,
  output logic                out_tvalid,
  input  logic                out_tready,
  output swms_pkg::swms_cmd_t cmd,
  input  swms_pkg::swms_sts_t sts
);
  import swms_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CAND = 7'b0000010,  // read candidate i
    S_CLR  = 7'b0000100,  // capture candidate, clear counters
    S_CMP  = 7'b0001000,  // issue first compare read
    S_TAIL = 7'b0010000,  // accumulate compare returns, issue further reads
    S_CHK  = 7'b0100000,  // check rank
    S_FIN  = 7'b1000000   // sum update, output load
  } state_t;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   accept;

  // new word taken only in idle and once the previous result is gone
  assign in_tready  = (state_r == S_IDLE) && !ovalid_r;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;
    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.take  = 1'b1;
          cmd.clear = in_start;
          if (sts.full) begin
            state_nxt = S_CAND;
          end
        end
      end
      S_CAND: begin
        state_nxt = S_CLR;
      end
      S_CLR: begin
        cmd.cmp_clr = 1'b1;
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        cmd.cmp_rd  = 1'b1;
        state_nxt   = S_TAIL;
      end
      S_TAIL: begin
        cmd.cmp_acc = 1'b1;
        if (sts.last_j) begin
          state_nxt = S_CHK;
        end else begin
          cmd.cmp_rd = 1'b1;
        end
      end
      S_CHK: begin
        if (sts.hit || sts.last_i) begin
          state_nxt = S_FIN;
        end else begin
          cmd.cand_nx = 1'b1;
          state_nxt   = S_CAND;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        ovalid_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // candidate read address uses i during S_CAND
    if (state_r == S_CAND) begin
      cmd.cand_ld = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end
endmodule

[hw/rtl/swms_checker.sv]
// Port-level checker for sliding_window_median_sum, with bind.
// Depends on the top level's ports only.
module swms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);
  // result word holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  // no input taken while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready with pending result");

  // a result never appears the cycle after an input accept
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("result too early");
endmodule

bind sliding_window_median_sum swms_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

[sim/tb.sv]
// Testbench for sliding_window_median_sum: streams samples with random gaps and
// output stalls, predicts lower median and saturating sum, checks every word.
// Depends on swms_pkg and the sliding_window_median_sum RTL.
module tb;
  import swms_pkg::*;

  typedef struct {
    logic [15:0] median;
    logic [47:0] msum;
  } median_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [KCFG_BITS-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;

  // predictor state
  logic [15:0] ring [MAX_WINDOW];
  int unsigned wr_pos;
  int unsigned fill;
  logic [47:0] med_sum;
  logic [6:0] win_cfg;

  median_word_t median_q[$];
  int errors = 0;
  int burst_left = 0;

  sliding_window_median_sum dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predict the result of one accepted word
  task automatic predict_median(input logic [15:0] s, input logic start);
    int unsigned k, rank, p, less, leq;
    logic [15:0] vals [MAX_WINDOW];
    median_word_t w;
    if (start) begin
      wr_pos = 0;
      fill = 0;
      med_sum = '0;
    end
    ring[wr_pos] = s;
    wr_pos = (wr_pos + 1) % MAX_WINDOW;
    if (fill < MAX_WINDOW) fill++;
    k = (win_cfg == 0) ? 1 : ((win_cfg > MAX_WINDOW) ? MAX_WINDOW : win_cfg);
    if (fill < k) return;
    rank = (k + 1) / 2;
    p = wr_pos;
    for (int i = 0; i < k; i++) begin
      p = (p == 0) ? MAX_WINDOW - 1 : p - 1;
      vals[i] = ring[p];
    end
    w.median = '0;
    for (int i = 0; i < k; i++) begin
      less = 0;
      leq = 0;
      for (int j = 0; j < k; j++) begin
        if (vals[j] < vals[i]) less++;
        if (vals[j] <= vals[i]) leq++;
      end
      if (less < rank && rank <= leq) begin
        w.median = vals[i];
        break;
      end
    end
    if ({1'b0, med_sum} + w.median > {1'b0, SUM_MAX}) med_sum = SUM_MAX;
    else med_sum = med_sum + w.median;
    w.msum = med_sum;
    median_q.push_back(w);
  endtask

  // send one word; sender runs in bursts with random gaps
  task automatic send_sample(input logic [15:0] s, input logic start);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s;
    in_tuser <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_median(s, start);
    burst_left--;
  endtask

  task automatic drain_wait();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (median_q.size() != 0) @(posedge clk);
    // a word with no result may still be in flight
    repeat (64 * 67 + 10) @(posedge clk);
  endtask

  task automatic write_window(input int unsigned k);
    drain_wait();
    cfg_we <= 1'b1;
    cfg_wdata <= k[6:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    win_cfg = k[6:0];
  endtask

  // receiver: stall pattern plus result check
  always @(posedge clk) begin
    median_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (median_q.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        errors++;
      end else begin
        w = median_q.pop_front();
        if (out_tdata[15:0] !== w.median) begin
          $error("median: expected %h, got %h", w.median, out_tdata[15:0]);
          errors++;
        end
        if (out_tdata[63:16] !== w.msum) begin
          $error("median_sum: expected %h, got %h", w.msum, out_tdata[63:16]);
          errors++;
        end
      end
    end
    out_tready <= (($urandom_range(0, 99) % 8) < 5) || ($urandom_range(0, 3) == 0);
  end

  task automatic test_extremes();
    send_sample(16'h0000, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b0);
  endtask

  task automatic test_sizes();
    write_window(0);
    send_sample(16'h1234, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    write_window(1);
    send_sample(16'h0007, 1'b0);
    write_window(4);
    for (int i = 0; i < 5; i++) send_sample(16'($urandom()), 1'b0);
    // shrink mid-sequence, then grow beyond what has been taken
    write_window(2);
    send_sample(16'h0100, 1'b0);
    write_window(127);
    for (int i = 0; i < 66; i++) send_sample(16'($urandom()), i == 0);
    write_window(64);
    send_sample(16'hFFFF, 1'b0);
  endtask

  task automatic test_saturation();
    // size 1 with max samples climbs fast only in long runs; preload via a
    // long stream is too slow, so check sum keeps adding at size 1
    write_window(1);
    for (int i = 0; i < 20; i++) send_sample(16'hFFFF, i == 0);
  endtask

  task automatic test_random();
    int unsigned sizes [6] = '{1, 2, 3, 5, 8, 64};
    for (int ph = 0; ph < 6; ph++) begin
      write_window(sizes[ph] == 64 ? 64 : $urandom_range(1, sizes[ph] + 2));
      for (int i = 0; i < (sizes[ph] == 64 ? 80 : 170); i++)
        send_sample(16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom()),
                    $urandom_range(0, 40) == 0);
    end
  endtask

  initial begin
    win_cfg = 7'd3;
    wr_pos = 0;
    fill = 0;
    med_sum = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_sizes();
    test_saturation();
    test_random();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (median_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && median_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200_000_000;
    $display("Mismatches found");
    $finish;
  end
endmodule
